@@ rtl/rsz_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rsz_pkg
// Shared types, widths and codes of the bilinear resize block.
// -----------------------------------------------------------------------------
package rsz_pkg;

	localparam int MAX_SRC_WIDTH_D  = 256;
	localparam int MAX_SRC_HEIGHT_D = 256;
	localparam int MAX_CHANNELS_D   = 4;
	localparam int PIXEL_BITS_D     = 16;

	localparam int MAX_DST   = 1024;
	localparam int SRC_W     = 9;
	localparam int DST_W     = 11;
	localparam int NCH_W     = 3;
	localparam int POS_W     = 10;
	localparam int CHAN_W    = 2;
	localparam int PIX_W     = 16;
	localparam int FRAC_W    = 16;
	localparam int WGT_W     = FRAC_W + 1;
	localparam int SCALE_W   = SRC_W + FRAC_W;
	localparam int CIDX_W    = 3;
	localparam int CDATA_W   = 11;
	localparam int TAP_W     = SRC_W;

	typedef enum logic [CIDX_W-1:0] {
		REG_SRC_WIDTH  = 3'd0,
		REG_SRC_HEIGHT = 3'd1,
		REG_DST_WIDTH  = 3'd2,
		REG_DST_HEIGHT = 3'd3,
		REG_NUM_CHAN   = 3'd4
	} cfg_reg_t;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef struct packed {
		logic vld;
		logic req;
		logic err;
	} rsz_ctl_t;

endpackage

@@ rtl/rsz_div.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rsz_div
// Restoring divider, one quotient bit per cycle: scale = (src << 16) / dst.
// -----------------------------------------------------------------------------
module rsz_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       kick,
	input  logic [rsz_pkg::SRC_W-1:0]  src,
	input  logic [rsz_pkg::DST_W-1:0]  dst,
	output logic                       busy,
	output logic [rsz_pkg::SCALE_W-1:0] scale
);
	import rsz_pkg::*;

	localparam int CNT_W = $clog2(SCALE_W + 1);

	logic [CNT_W-1:0]   cnt_q;
	logic [DST_W-1:0]   rem_q;
	logic [SCALE_W-1:0] quo_q;
	logic [DST_W:0]     rem_sh;
	logic [DST_W:0]     rem_sub;
	logic               sub_ok;

	assign rem_sh  = {rem_q, quo_q[SCALE_W-1]};
	assign rem_sub = rem_sh - {1'b0, dst};
	assign sub_ok  = (rem_sh >= {1'b0, dst});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
		end else if (kick) begin
			cnt_q <= CNT_W'(SCALE_W);
			rem_q <= '0;
			quo_q <= {src, {FRAC_W{1'b0}}};
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			rem_q <= sub_ok ? rem_sub[DST_W-1:0] : rem_sh[DST_W-1:0];
			quo_q <= {quo_q[SCALE_W-2:0], sub_ok};
		end
	end

	assign busy  = (cnt_q != '0);
	assign scale = quo_q;
endmodule

@@ rtl/rsz_axis.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rsz_axis
// Two-stage coordinate map of one axis: centre to source, taps and fraction.
// -----------------------------------------------------------------------------
module rsz_axis (
	input  logic                        clk,
	input  logic [rsz_pkg::POS_W-1:0]   pos,
	input  logic [rsz_pkg::SCALE_W-1:0] scale,
	input  logic [rsz_pkg::SRC_W-1:0]   src,
	output logic [rsz_pkg::TAP_W-1:0]   tap0_s3,
	output logic [rsz_pkg::TAP_W-1:0]   tap1_s3,
	output logic [rsz_pkg::FRAC_W-1:0]  frac_s3
);
	import rsz_pkg::*;

	localparam int PROD_W = POS_W + 1 + SCALE_W;
	localparam int IDX_W  = PROD_W - 1 - FRAC_W;

	logic [PROD_W-1:0] prod_s2;
	logic [PROD_W-2:0] half;
	logic [PROD_W-2:0] s;
	logic [IDX_W-1:0]  idx;
	logic [TAP_W-1:0]  last;
	logic [TAP_W-1:0]  t0;

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'({pos, 1'b1}) * PROD_W'(scale);
	end

	always_comb begin
		half = prod_s2[PROD_W-1:1];
		s    = (half < (PROD_W-1)'(32768)) ? '0 : half - (PROD_W-1)'(32768);
		idx  = s[PROD_W-2:FRAC_W];
		last = src - 1'b1;
		t0   = (idx > IDX_W'(last)) ? last : idx[TAP_W-1:0];
	end

	always_ff @(posedge clk) begin
		tap0_s3 <= t0;
		tap1_s3 <= (t0 == last) ? last : t0 + 1'b1;
		frac_s3 <= s[FRAC_W-1:0];
	end
endmodule

@@ rtl/rsz_store.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rsz_store
// Frame store in four banks by column and row parity; four taps per cycle.
// -----------------------------------------------------------------------------
module rsz_store #(
	parameter int MAX_SRC_WIDTH  = rsz_pkg::MAX_SRC_WIDTH_D,
	parameter int MAX_SRC_HEIGHT = rsz_pkg::MAX_SRC_HEIGHT_D,
	parameter int MAX_CHANNELS   = rsz_pkg::MAX_CHANNELS_D,
	parameter int PIXEL_BITS     = rsz_pkg::PIXEL_BITS_D
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [rsz_pkg::TAP_W-1:0]  wx,
	input  logic [rsz_pkg::TAP_W-1:0]  wy,
	input  logic [rsz_pkg::CHAN_W-1:0] wc,
	input  logic [PIXEL_BITS-1:0]      wdata,
	input  logic [rsz_pkg::TAP_W-1:0]  x0,
	input  logic [rsz_pkg::TAP_W-1:0]  x1,
	input  logic [rsz_pkg::TAP_W-1:0]  y0,
	input  logic [rsz_pkg::TAP_W-1:0]  y1,
	input  logic [rsz_pkg::CHAN_W-1:0] rc,
	output logic [PIXEL_BITS-1:0]      q00,
	output logic [PIXEL_BITS-1:0]      q10,
	output logic [PIXEL_BITS-1:0]      q01,
	output logic [PIXEL_BITS-1:0]      q11
);
	import rsz_pkg::*;

	localparam int HW = (MAX_SRC_WIDTH + 1) / 2;
	localparam int HH = (MAX_SRC_HEIGHT + 1) / 2;
	localparam int BD = HW * HH * MAX_CHANNELS;
	localparam int AW = (BD > 1) ? $clog2(BD) : 1;

	function automatic logic [AW-1:0] baddr(input logic [TAP_W-1:0] x,
	                                        input logic [TAP_W-1:0] y,
	                                        input logic [CHAN_W-1:0] c);
		int a;
		a = ((int'(y >> 1) * HW) + int'(x >> 1)) * MAX_CHANNELS + int'(c);
		return AW'(a);
	endfunction

	logic [PIXEL_BITS-1:0] rd_q [4];
	logic [1:0]            par_q;
	logic [1:0]            par1_q;

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [PIXEL_BITS-1:0] mem [BD];
		logic [TAP_W-1:0]      cx;
		logic [TAP_W-1:0]      cy;

		assign cx = (x0[0] == b[0]) ? x0 : x1;
		assign cy = (y0[0] == b[1]) ? y0 : y1;

		always_ff @(posedge clk) begin
			if (we && wx[0] == b[0] && wy[0] == b[1]) begin
				mem[baddr(wx, wy, wc)] <= wdata;
			end
			rd_q[b] <= mem[baddr(cx, cy, rc)];
		end
	end

	always_ff @(posedge clk) begin
		par_q  <= {y0[0], x0[0]};
		par1_q <= {y1[0], x1[0]};
	end

	assign q00 = rd_q[{par_q[1],  par_q[0]}];
	assign q10 = rd_q[{par_q[1],  par1_q[0]}];
	assign q01 = rd_q[{par1_q[1], par_q[0]}];
	assign q11 = rd_q[{par1_q[1], par1_q[0]}];
endmodule

@@ rtl/rsz_blend.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rsz_blend
// Three-stage weighted blend of four taps with round to nearest.
// -----------------------------------------------------------------------------
module rsz_blend #(
	parameter int PIXEL_BITS = rsz_pkg::PIXEL_BITS_D
) (
	input  logic                       clk,
	input  logic [PIXEL_BITS-1:0]      p00,
	input  logic [PIXEL_BITS-1:0]      p10,
	input  logic [PIXEL_BITS-1:0]      p01,
	input  logic [PIXEL_BITS-1:0]      p11,
	input  logic [rsz_pkg::FRAC_W-1:0] fx,
	input  logic [rsz_pkg::FRAC_W-1:0] fy,
	output logic [rsz_pkg::PIX_W-1:0]  pix
);
	import rsz_pkg::*;

	localparam int HW_ = PIXEL_BITS + WGT_W;
	localparam int MW  = HW_ + WGT_W;
	localparam int FW  = (MW + 1 > 48) ? MW + 1 : 48;

	logic [WGT_W-1:0] wx0;
	logic [WGT_W-1:0] wy0_s5;
	logic [WGT_W-1:0] wy0_s6;
	logic [FRAC_W-1:0] fy_s5;
	logic [FRAC_W-1:0] fy_s6;
	logic [HW_-1:0]   h00_s5, h10_s5, h01_s5, h11_s5;
	logic [HW_-1:0]   top_s6, bot_s6;
	logic [MW-1:0]    mt_s7, mb_s7;
	logic [FW-1:0]    full;

	assign wx0 = WGT_W'(65536) - WGT_W'(fx);

	always_ff @(posedge clk) begin
		h00_s5 <= HW_'(p00) * HW_'(wx0);
		h10_s5 <= HW_'(p10) * HW_'(fx);
		h01_s5 <= HW_'(p01) * HW_'(wx0);
		h11_s5 <= HW_'(p11) * HW_'(fx);
		wy0_s5 <= WGT_W'(65536) - WGT_W'(fy);
		fy_s5  <= fy;
		top_s6 <= h00_s5 + h10_s5;
		bot_s6 <= h01_s5 + h11_s5;
		wy0_s6 <= wy0_s5;
		fy_s6  <= fy_s5;
		mt_s7  <= MW'(top_s6) * MW'(wy0_s6);
		mb_s7  <= MW'(bot_s6) * MW'(fy_s6);
	end

	assign full = FW'(mt_s7) + FW'(mb_s7) + FW'(64'h8000_0000);
	assign pix  = full[47:32];
endmodule

@@ rtl/bilinear_image_resize.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bilinear_image_resize
// Frame store with half-pixel-centre bilinear resize queries.
//
// channel  | ports                                        | handshake
// request  | req_type pos_x pos_y chan pixel_in           | start, busy
// result   | pixel_out status                             | done strobe
// config   | cfg_idx cfg_data                             | cfg_we
//
// One request enters per cycle while busy is low; each result passes ctl_s1 to
// ctl_s7 and the output registers. After reset and after every register write,
// busy stays high while the scale dividers run one quotient bit per cycle.
// The result side cannot stall; results are strobed for one cycle.
// -----------------------------------------------------------------------------
module bilinear_image_resize #(
	parameter int MAX_SRC_WIDTH  = rsz_pkg::MAX_SRC_WIDTH_D,
	parameter int MAX_SRC_HEIGHT = rsz_pkg::MAX_SRC_HEIGHT_D,
	parameter int MAX_CHANNELS   = rsz_pkg::MAX_CHANNELS_D,
	parameter int PIXEL_BITS     = rsz_pkg::PIXEL_BITS_D
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        req_type,
	input  logic [rsz_pkg::POS_W-1:0]   pos_x,
	input  logic [rsz_pkg::POS_W-1:0]   pos_y,
	input  logic [rsz_pkg::CHAN_W-1:0]  chan,
	input  logic [rsz_pkg::PIX_W-1:0]   pixel_in,
	output logic                        done,
	output logic [rsz_pkg::PIX_W-1:0]   pixel_out,
	output logic                        status,
	input  logic                        cfg_we,
	input  logic [rsz_pkg::CIDX_W-1:0]  cfg_idx,
	input  logic [rsz_pkg::CDATA_W-1:0] cfg_data
);
	import rsz_pkg::*;

	localparam int SW_RST = (MAX_SRC_WIDTH < 256) ? MAX_SRC_WIDTH : 256;
	localparam int SH_RST = (MAX_SRC_HEIGHT < 256) ? MAX_SRC_HEIGHT : 256;
	localparam int NC_RST = 1;

	logic [SRC_W-1:0] src_w_q, src_h_q;
	logic [DST_W-1:0] dst_w_q, dst_h_q;
	logic [NCH_W-1:0] nch_q;
	logic             kick_q;
	logic             bx, by;
	logic [SCALE_W-1:0] scl_x, scl_y;

	logic [SRC_W-1:0] v9;
	logic [DST_W-1:0] v11;
	logic [NCH_W-1:0] v3;

	assign v9  = cfg_data[SRC_W-1:0];
	assign v11 = cfg_data[DST_W-1:0];
	assign v3  = cfg_data[NCH_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SRC_W'(SW_RST);
			src_h_q <= SRC_W'(SH_RST);
			dst_w_q <= DST_W'(256);
			dst_h_q <= DST_W'(256);
			nch_q   <= NCH_W'(NC_RST);
			kick_q  <= 1'b1;
		end else begin
			kick_q <= cfg_we;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_SRC_WIDTH:  src_w_q <= (v9 == '0) ? SRC_W'(1) :
						(int'(v9) > MAX_SRC_WIDTH) ? SRC_W'(MAX_SRC_WIDTH) : v9;
					REG_SRC_HEIGHT: src_h_q <= (v9 == '0) ? SRC_W'(1) :
						(int'(v9) > MAX_SRC_HEIGHT) ? SRC_W'(MAX_SRC_HEIGHT) : v9;
					REG_DST_WIDTH:  dst_w_q <= (v11 == '0) ? DST_W'(1) :
						(int'(v11) > MAX_DST) ? DST_W'(MAX_DST) : v11;
					REG_DST_HEIGHT: dst_h_q <= (v11 == '0) ? DST_W'(1) :
						(int'(v11) > MAX_DST) ? DST_W'(MAX_DST) : v11;
					REG_NUM_CHAN:   nch_q <= (v3 == '0) ? NCH_W'(1) :
						(int'(v3) > MAX_CHANNELS) ? NCH_W'(MAX_CHANNELS) : v3;
					default: ;
				endcase
			end
		end
	end

	rsz_div u_div_x (.clk, .arst_n, .kick(kick_q), .src(src_w_q), .dst(dst_w_q),
		.busy(bx), .scale(scl_x));
	rsz_div u_div_y (.clk, .arst_n, .kick(kick_q), .src(src_h_q), .dst(dst_h_q),
		.busy(by), .scale(scl_y));

	assign busy = kick_q | bx | by;

	// request stage
	rsz_ctl_t           ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	logic [POS_W-1:0]   x_s1, y_s1, x_s2, y_s2, x_s3, y_s3;
	logic [CHAN_W-1:0]  c_s1, c_s2, c_s3;
	logic [PIX_W-1:0]   pix_s1, pix_s2, pix_s3;
	logic               err;

	always_comb begin
		if (req_type == REQ_WRITE) begin
			err = ({1'b0, pos_x} >= DST_W'(src_w_q)) || ({1'b0, pos_y} >= DST_W'(src_h_q));
		end else begin
			err = ({1'b0, pos_x} >= dst_w_q) || ({1'b0, pos_y} >= dst_h_q);
		end
		err = err || (NCH_W'(chan) >= nch_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else begin
			ctl_s1 <= '{vld: start & ~busy, req: req_type, err: err};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
		end
	end

	always_ff @(posedge clk) begin
		x_s1   <= pos_x;
		y_s1   <= pos_y;
		c_s1   <= chan;
		pix_s1 <= pixel_in;
		x_s2   <= x_s1;
		y_s2   <= y_s1;
		c_s2   <= c_s1;
		pix_s2 <= pix_s1;
		x_s3   <= x_s2;
		y_s3   <= y_s2;
		c_s3   <= c_s2;
		pix_s3 <= pix_s2;
	end

	// coordinate map
	logic [TAP_W-1:0]  x0_s3, x1_s3, y0_s3, y1_s3;
	logic [FRAC_W-1:0] fx_s3, fy_s3, fx_s4, fy_s4;

	rsz_axis u_ax_x (.clk, .pos(x_s1), .scale(scl_x), .src(src_w_q),
		.tap0_s3(x0_s3), .tap1_s3(x1_s3), .frac_s3(fx_s3));
	rsz_axis u_ax_y (.clk, .pos(y_s1), .scale(scl_y), .src(src_h_q),
		.tap0_s3(y0_s3), .tap1_s3(y1_s3), .frac_s3(fy_s3));

	always_ff @(posedge clk) begin
		fx_s4 <= fx_s3;
		fy_s4 <= fy_s3;
	end

	// frame store
	logic [PIXEL_BITS-1:0] p00, p10, p01, p11;
	logic                  wr_en;

	assign wr_en = ctl_s3.vld && (ctl_s3.req == REQ_WRITE) && !ctl_s3.err;

	rsz_store #(
		.MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
		.MAX_CHANNELS(MAX_CHANNELS), .PIXEL_BITS(PIXEL_BITS)
	) u_store (
		.clk, .we(wr_en), .wx(x_s3[TAP_W-1:0]), .wy(y_s3[TAP_W-1:0]), .wc(c_s3),
		.wdata(PIXEL_BITS'(pix_s3)), .x0(x0_s3), .x1(x1_s3), .y0(y0_s3), .y1(y1_s3),
		.rc(c_s3), .q00(p00), .q10(p10), .q01(p01), .q11(p11)
	);

	// blend
	logic [PIX_W-1:0] blend_pix;

	rsz_blend #(.PIXEL_BITS(PIXEL_BITS)) u_blend (
		.clk, .p00, .p10, .p01, .p11, .fx(fx_s4), .fy(fy_s4), .pix(blend_pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_s7.vld;
		end
	end

	always_ff @(posedge clk) begin
		status    <= ctl_s7.err ? STATUS_ERR : STATUS_OK;
		pixel_out <= (ctl_s7.req == REQ_QUERY && !ctl_s7.err) ? blend_pix : '0;
	end
endmodule

@@ rtl/rsz_chk.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rsz_chk
// Port-level checks of the bilinear resize block.
// -----------------------------------------------------------------------------
module rsz_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [rsz_pkg::PIX_W-1:0]   pixel_out,
	input logic                        status,
	input logic                        cfg_we
);
	import rsz_pkg::*;

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##8 done)
		else $error("result missing for accepted request");

	a_no_spur: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##8 !done)
		else $error("result without request");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STATUS_ERR) |-> (pixel_out == '0))
		else $error("rejected request returned data");

	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> busy)
		else $error("register write did not hold off requests");
endmodule

bind bilinear_image_resize rsz_chk u_rsz_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.pixel_out(pixel_out), .status(status), .cfg_we(cfg_we)
);
